// File: sv/lcsb_pkg.sv
// Shared types and constants for the link connect supervisor.
package lcsb_pkg;

    localparam int DELAY_W = 22;
    localparam int YEAR_W  = 12;
    localparam int TIME_W  = 32;
    localparam int STATE_W = 3;
    localparam int CFG_IDX_W = 2;

    // request kinds on the input word
    localparam logic [1:0] KIND_POLL   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_FORCE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR   = 2'd3;

    localparam logic [DELAY_W-1:0] RST_BASE_DELAY = 22'd1000;
    localparam logic [DELAY_W-1:0] RST_MAX_DELAY  = 22'd60000;
    localparam logic [DELAY_W-1:0] RST_TIMEOUT    = 22'd10000;
    localparam logic [YEAR_W-1:0]  RST_MIN_YEAR   = 12'd2024;

    typedef enum logic [1:0] {
        OP_POLL,
        OP_START,
        OP_FORCE,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] now_ms;
        logic              link_up;
        logic              year_known;
        logic [YEAR_W-1:0] clock_year;
    } t_in_word;

    typedef struct packed {
        logic [STATE_W-1:0] link_state;
        logic               begin_connect;
        logic               drop_link;
        logic               start_time_sync;
        logic               time_synced;
        logic [DELAY_W-1:0] backoff_ms;
    } t_out_word;

    // classified command held in the queue
    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] now_ms;
        logic              link_up;
        logic              year_ok;
    } t_cmd;

endpackage

// File: sv/lcsb_front.sv
// Front end: takes input words and classifies them into queue commands.
module lcsb_front
    import lcsb_pkg::*;
(
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_word          i_data,
    input  logic [YEAR_W-1:0] i_min_year,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_cmd              o_q_cmd
);

    t_op w_op;

    always_comb begin
        case (i_data.kind)
            KIND_POLL:  w_op = OP_POLL;
            KIND_START: w_op = OP_START;
            KIND_FORCE: w_op = OP_FORCE;
            default:    w_op = OP_NONE;
        endcase
    end

    assign o_stall          = i_q_full;
    assign o_q_push         = i_valid && !i_q_full;
    assign o_q_cmd.op       = w_op;
    assign o_q_cmd.now_ms   = i_data.now_ms;
    assign o_q_cmd.link_up  = i_data.link_up;
    // year check resolved here; the user must change min year only while idle, the block does not enforce it
    assign o_q_cmd.year_ok  = i_data.year_known && (i_data.clock_year >= i_min_year);

endmodule

// File: sv/lcsb_queue.sv
// Short command queue between front and back ends.
module lcsb_queue
    import lcsb_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: sv/lcsb_back.sv
// Back end: link state machine, backoff timing and the output register.
module lcsb_back
    import lcsb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_cmd               i_q_cmd,
    output logic               o_q_pop,
    input  logic [DELAY_W-1:0] i_base_delay,
    input  logic [DELAY_W-1:0] i_max_delay,
    input  logic [DELAY_W-1:0] i_timeout,
    output logic               o_valid,
    input  logic               i_stall,
    output t_out_word          o_data
);

    typedef enum logic [STATE_W-1:0] {
        ST_DISCONNECTED = 3'd0,
        ST_CONNECTING   = 3'd1,
        ST_SYNCING      = 3'd2,
        ST_CONNECTED    = 3'd3,
        ST_READY        = 3'd4
    } t_state;

    t_state             r_state,       n_state;
    logic [TIME_W-1:0]  r_attempt_ms,  n_attempt_ms;
    logic [TIME_W-1:0]  r_last_retry,  n_last_retry;
    logic [DELAY_W-1:0] r_delay,       n_delay;
    logic               r_synced,      n_synced;
    logic               r_out_valid;
    t_out_word          r_out,         n_out;

    logic               w_begin, w_drop, w_sync;
    logic [TIME_W-1:0]  w_since_attempt;
    logic [TIME_W-1:0]  w_since_retry;
    logic [DELAY_W:0]   w_doubled;

    assign o_q_pop = i_q_valid && (!r_out_valid || !i_stall);

    assign w_since_attempt = i_q_cmd.now_ms - r_attempt_ms;
    assign w_since_retry   = i_q_cmd.now_ms - r_last_retry;
    assign w_doubled       = {r_delay, 1'b0};

    always_comb begin
        n_state      = r_state;
        n_attempt_ms = r_attempt_ms;
        n_last_retry = r_last_retry;
        n_delay      = r_delay;
        n_synced     = r_synced;
        w_begin      = 1'b0;
        w_drop       = 1'b0;
        w_sync       = 1'b0;
        case (i_q_cmd.op)
            OP_START: begin
                w_begin      = 1'b1;
                n_attempt_ms = i_q_cmd.now_ms;
                n_state      = ST_CONNECTING;
            end
            OP_FORCE: begin
                w_drop       = 1'b1;
                n_state      = ST_DISCONNECTED;
                n_last_retry = '0;
                n_delay      = i_base_delay;
            end
            OP_POLL: begin
                case (r_state)
                    ST_CONNECTING: begin
                        if (i_q_cmd.link_up) begin
                            n_delay = i_base_delay;
                            w_sync  = 1'b1;
                            n_state = ST_SYNCING;
                        end else if (w_since_attempt > TIME_W'(i_timeout)) begin
                            w_drop       = 1'b1;
                            n_state      = ST_DISCONNECTED;
                            n_last_retry = i_q_cmd.now_ms;
                        end
                    end
                    ST_SYNCING: begin
                        if (!i_q_cmd.link_up) begin
                            n_state  = ST_DISCONNECTED;
                            n_synced = 1'b0;
                        end else if (i_q_cmd.year_ok) begin
                            n_synced = 1'b1;
                            n_state  = ST_READY;
                        end
                    end
                    ST_CONNECTED: begin
                        if (!i_q_cmd.link_up) begin
                            n_state = ST_DISCONNECTED;
                        end
                    end
                    ST_READY: begin
                        if (!i_q_cmd.link_up) begin
                            n_state  = ST_DISCONNECTED;
                            n_synced = 1'b0;
                        end
                    end
                    ST_DISCONNECTED: begin
                        if (w_since_retry >= TIME_W'(r_delay)) begin
                            w_begin      = 1'b1;
                            n_attempt_ms = i_q_cmd.now_ms;
                            n_state      = ST_CONNECTING;
                            // doubled below the cap always fits in the delay width
                            n_delay = (w_doubled < (DELAY_W+1)'(i_max_delay))
                                      ? w_doubled[DELAY_W-1:0] : i_max_delay;
                        end
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
            end
            default: begin
                n_state = r_state;
            end
        endcase
        n_out.link_state      = n_state;
        n_out.begin_connect   = w_begin;
        n_out.drop_link       = w_drop;
        n_out.start_time_sync = w_sync;
        n_out.time_synced     = n_synced;
        n_out.backoff_ms      = n_delay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_DISCONNECTED;
            r_attempt_ms <= '0;
            r_last_retry <= '0;
            r_delay      <= RST_BASE_DELAY;
            r_synced     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_state      <= n_state;
                r_attempt_ms <= n_attempt_ms;
                r_last_retry <= n_last_retry;
                r_delay      <= n_delay;
                r_synced     <= n_synced;
                r_out_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// File: sv/link_connect_supervisor_backoff.sv
// Top level of the link connect supervisor with exponential reconnect backoff.
// Sustains one word per clock cycle in and one result word per cycle out while
// i_stall is low; the rate is set by the back end's state update of each word.
// A result passes from the input through the command queue and the back end's
// output register to o_data, and is held there while the output is stalled; the
// queue between front and back end holds QUEUE_DEPTH words so the input keeps
// flowing while a result waits, until the queue is full. The
// configuration registers are written through i_cfg_wr_en/i_cfg_idx/i_cfg_data
// and should only be changed while no word is in flight.
module link_connect_supervisor_backoff
    import lcsb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_word             i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_word            o_data,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DELAY_W-1:0]   i_cfg_data
);

    logic [DELAY_W-1:0] r_base_delay;
    logic [DELAY_W-1:0] r_max_delay;
    logic [DELAY_W-1:0] r_timeout;
    logic [YEAR_W-1:0]  r_min_year;

    logic w_q_full, w_q_push, w_q_valid, w_q_pop;
    t_cmd w_push_cmd, w_pop_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_delay <= RST_BASE_DELAY;
            r_max_delay  <= RST_MAX_DELAY;
            r_timeout    <= RST_TIMEOUT;
            r_min_year   <= RST_MIN_YEAR;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_BASE_DELAY: r_base_delay <= i_cfg_data;
                CFG_MAX_DELAY:  r_max_delay  <= i_cfg_data;
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                CFG_MIN_YEAR:   r_min_year   <= i_cfg_data[YEAR_W-1:0];
                default:        r_base_delay <= r_base_delay;
            endcase
        end
    end

    lcsb_front u_front (
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .i_min_year (r_min_year),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_cmd    (w_push_cmd)
    );

    lcsb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_pop_cmd)
    );

    lcsb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_cmd      (w_pop_cmd),
        .o_q_pop      (w_q_pop),
        .i_base_delay (r_base_delay),
        .i_max_delay  (r_max_delay),
        .i_timeout    (r_timeout),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

endmodule
